### hdl/oss_pkg.sv
package oss_pkg;

   localparam int DATA_W           = 32;
   localparam int CMD_W            = 3;
   localparam int POS_W            = 6;
   localparam int INDEX_W          = 6;
   localparam int COUNT_W          = 7;
   localparam int DEFAULT_CAPACITY = 64;

   // Cells examined per scan cycle.
   localparam int GROUP_SIZE = 8;
   localparam int GROUP_W    = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND    = 3'd0,
      CMD_FIND      = 3'd1,
      CMD_READ_AT   = 3'd2,
      CMD_REMOVE_AT = 3'd3,
      CMD_READ_NEXT = 3'd4,
      CMD_COUNT     = 3'd5
   } cmd_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic mark;       // capture match flag and gated value
      logic find_mode;  // match on key instead of position
      logic append;     // cell at the tail takes the data word
      logic shift;      // cells at and above target take their neighbor
   } cell_ctrl_type;

endpackage

### hdl/oss_cell.sv
module oss_cell #(
   parameter int IDX = 0,
   parameter int KW  = 7
) (
   input  logic                        clock,
   input  oss_pkg::cell_ctrl_type      ctrl,
   input  logic [oss_pkg::DATA_W-1:0]  key,
   input  logic [oss_pkg::DATA_W-1:0]  data,
   input  logic [KW-1:0]               target,
   input  logic [KW-1:0]               count,
   input  logic [oss_pkg::DATA_W-1:0]  next_value,
   output logic [oss_pkg::DATA_W-1:0]  value,
   output logic                        flag,
   output logic [oss_pkg::DATA_W-1:0]  cap
);
   import oss_pkg::*;

   localparam logic [KW-1:0] MY_IDX   = KW'(IDX);
   localparam logic [KW-1:0] NEXT_IDX = KW'(IDX + 1);

   logic [DATA_W-1:0] value_ff, value_in;
   logic              flag_ff, flag_in;
   logic [DATA_W-1:0] cap_ff, cap_in;
   logic              hit;

   always_comb begin
      if (ctrl.find_mode) begin
         hit = (value_ff == key) && (MY_IDX < count);
      end else begin
         hit = (MY_IDX == target);
      end

      flag_in  = flag_ff;
      cap_in   = cap_ff;
      value_in = value_ff;
      if (ctrl.mark) begin
         flag_in = hit;
         cap_in  = hit ? value_ff : '0;
      end
      if (ctrl.append && (MY_IDX == count)) begin
         value_in = data;
      end else if (ctrl.shift && (MY_IDX >= target) && (NEXT_IDX < count)) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      flag_ff  <= flag_in;
      cap_ff   <= cap_in;
   end

   assign value = value_ff;
   assign flag  = flag_ff;
   assign cap   = cap_ff;

endmodule

### hdl/oss_scan.sv
module oss_scan #(
   parameter int CAPACITY = oss_pkg::DEFAULT_CAPACITY,
   parameter int NGROUP   = (CAPACITY + oss_pkg::GROUP_SIZE - 1) / oss_pkg::GROUP_SIZE,
   parameter int NCELL    = NGROUP * oss_pkg::GROUP_SIZE,
   parameter int GW       = (NGROUP > 1) ? $clog2(NGROUP) : 1,
   parameter int XW       = GW + oss_pkg::GROUP_W
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    find_mode,
   input  logic [GW-1:0]                           start_group,
   input  logic [NCELL-1:0]                        flags,
   input  logic [NCELL-1:0][oss_pkg::DATA_W-1:0]   caps,
   output logic                                    done,
   output logic                                    hit,
   output logic [XW-1:0]                           index,
   output logic [oss_pkg::DATA_W-1:0]              value
);
   import oss_pkg::*;

   localparam logic [GW-1:0] LAST_GROUP = GW'(NGROUP - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              find_ff, find_in;
   logic [GW-1:0]     group_ff, group_in;
   logic              hit_ff, hit_in;
   logic [XW-1:0]     index_ff, index_in;
   logic [DATA_W-1:0] value_ff, value_in;

   logic [GROUP_SIZE-1:0] sel_flags;
   logic [DATA_W-1:0]     sel_value;
   logic [GROUP_W-1:0]    prio;

   always_comb begin
      sel_flags = flags[group_ff*GROUP_SIZE +: GROUP_SIZE];
      sel_value = '0;
      prio      = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
         sel_value = sel_value | caps[group_ff*GROUP_SIZE + k];
      end
      // lowest set flag wins
      for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
         if (sel_flags[k]) prio = GROUP_W'(k);
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      find_in  = find_ff;
      group_in = group_ff;
      hit_in   = hit_ff;
      index_in = index_ff;
      value_in = value_ff;
      if (start) begin
         busy_in  = 1'b1;
         find_in  = find_mode;
         group_in = start_group;
      end else if (busy_ff) begin
         if ((|sel_flags) || !find_ff || (group_ff == LAST_GROUP)) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            hit_in   = |sel_flags;
            index_in = {group_ff, prio};
            value_in = sel_value;
         end else begin
            group_in = group_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      find_ff  <= find_in;
      group_ff <= group_in;
      hit_ff   <= hit_in;
      index_ff <= index_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign hit   = hit_ff;
   assign index = index_ff;
   assign value = value_ff;

endmodule

### hdl/ordered_sequence_store_top.sv
// Channel  Direction  Ports                                      Beat taken when
// req      in         req_command/data_value/search_key/position req_valid && req_ready
// rsp      out        rsp_result_value/result_index/element_count/ok
//                                                               rsp_valid && rsp_ready
//
// One command at a time; ready is high only between commands. Append, count, unknown
// codes and out-of-range reads pass from the setup step straight to the final step;
// read, read-next and remove scan one group of 8 cells in between; find scans groups
// of 8 cells, 1 to ceil(CAPACITY/8), in the single scan unit at 8 cells a cycle.
// Reset clears the entry count and the sequencer; cell contents stay undefined.
// A stalled rsp holds the result register; the next command is still accepted and
// waits in its final step until the result register frees.
module ordered_sequence_store_top #(
   parameter int CAPACITY = oss_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [oss_pkg::CMD_W-1:0]           req_command,
   input  logic signed [oss_pkg::DATA_W-1:0]   req_data_value,
   input  logic signed [oss_pkg::DATA_W-1:0]   req_search_key,
   input  logic [oss_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [oss_pkg::DATA_W-1:0]   rsp_result_value,
   output logic [oss_pkg::INDEX_W-1:0]         rsp_result_index,
   output logic [oss_pkg::COUNT_W-1:0]         rsp_element_count,
   output logic                                rsp_ok
);
   import oss_pkg::*;

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int KW     = (CW > POS_W + 1) ? CW : POS_W + 1;
   localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NCELL  = NGROUP * GROUP_SIZE;
   localparam int GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
   localparam int XW     = GW + GROUP_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MARK,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [DATA_W-1:0]    data_ff, data_in;
   logic [DATA_W-1:0]    key_ff, key_in;
   logic [KW-1:0]        target_ff, target_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_ok_ff, rsp_ok_in;

   cell_ctrl_type        ctrl;
   logic [KW-1:0]        count_ext;
   logic                 full;
   logic                 in_range;
   logic                 is_find;
   logic                 is_read;
   logic                 need_scan;
   logic                 advance;
   logic                 scan_start;
   logic [31:0]          count_wide;
   logic [31:0]          index_wide;

   logic [CAPACITY-1:0][DATA_W-1:0] cell_value;
   logic [NCELL-1:0]                cell_flag;
   logic [NCELL-1:0][DATA_W-1:0]    cell_cap;

   logic                 scan_done;
   logic                 scan_hit;
   logic [XW-1:0]        scan_index;
   logic [DATA_W-1:0]    scan_value;

   assign count_ext = KW'(count_ff);
   assign full      = (count_ff == CW'(CAPACITY));
   assign in_range  = (target_ff < count_ext);
   assign is_find   = (cmd_ff == CMD_FIND);
   assign is_read   = (cmd_ff == CMD_READ_AT) || (cmd_ff == CMD_READ_NEXT) ||
                      (cmd_ff == CMD_REMOVE_AT);
   assign need_scan = is_find || (is_read && in_range);
   assign advance   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign scan_start = (state_ff == S_MARK) && need_scan;

   // Broadcast to the row: mark during the setup step when a scan follows, write on the final step.
   always_comb begin
      ctrl.mark      = scan_start;
      ctrl.find_mode = is_find;
      ctrl.append    = advance && (cmd_ff == CMD_APPEND) && !full;
      ctrl.shift     = advance && (cmd_ff == CMD_REMOVE_AT) && in_range;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] neighbor;
      if (i == CAPACITY - 1) begin : g_tail
         assign neighbor = '0;
      end else begin : g_link
         assign neighbor = cell_value[i+1];
      end
      oss_cell #(
         .IDX (i),
         .KW  (KW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .key        (key_ff),
         .data       (data_ff),
         .target     (target_ff),
         .count      (count_ext),
         .next_value (neighbor),
         .value      (cell_value[i]),
         .flag       (cell_flag[i]),
         .cap        (cell_cap[i])
      );
   end

   // Pad the last scan group with empty slots.
   for (genvar i = CAPACITY; i < NCELL; i++) begin : g_pad
      assign cell_flag[i] = 1'b0;
      assign cell_cap[i]  = '0;
   end

   oss_scan #(
      .CAPACITY (CAPACITY),
      .NGROUP   (NGROUP),
      .NCELL    (NCELL),
      .GW       (GW),
      .XW       (XW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .find_mode   (is_find),
      .start_group (is_find ? GW'(0) : GW'(target_ff >> GROUP_W)),
      .flags       (cell_flag),
      .caps        (cell_cap),
      .done        (scan_done),
      .hit         (scan_hit),
      .index       (scan_index),
      .value       (scan_value)
   );

   assign index_wide = 32'(scan_index);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      data_in      = data_ff;
      key_in       = key_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ok_in    = rsp_ok_ff;
      count_wide   = 32'(count_ff);

      // drop the result register once the beat is taken
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_command;
               data_in = req_data_value;
               key_in  = req_search_key;
               if (req_command == CMD_READ_NEXT) begin
                  target_in = KW'(req_position) + 1'b1;
               end else begin
                  target_in = KW'(req_position);
               end
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            state_in = need_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            if (scan_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_index_in = '0;
               rsp_ok_in    = 1'b0;
               case (cmd_ff)
                  CMD_APPEND: begin
                     rsp_ok_in = !full;
                     if (!full) count_in = count_ff + 1'b1;
                  end
                  CMD_FIND: begin
                     rsp_ok_in = scan_hit;
                     if (scan_hit) rsp_index_in = index_wide[INDEX_W-1:0];
                  end
                  CMD_READ_AT, CMD_READ_NEXT: begin
                     rsp_ok_in = in_range;
                     if (in_range) rsp_value_in = scan_value;
                  end
                  CMD_REMOVE_AT: begin
                     rsp_ok_in = in_range;
                     if (in_range) begin
                        rsp_value_in = scan_value;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  CMD_COUNT: begin
                     rsp_ok_in = 1'b1;
                  end
                  default: begin
                     rsp_ok_in = 1'b0;
                  end
               endcase
               count_wide   = 32'(count_in);
               rsp_count_in = count_wide[COUNT_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      data_ff      <= data_in;
      key_ff       <= key_in;
      target_ff    <= target_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = rsp_value_ff;
   assign rsp_result_index  = rsp_index_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_ok            = rsp_ok_ff;

   // The entry count never runs past the store size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // A fresh result beat only comes out of the final step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result beat without a finished command");

   // A nonzero index belongs only to a successful find.
   a_index_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_index_ff != '0)) |-> rsp_ok_ff)
      else $error("index reported on a failed command");

   // The scan unit reports back only while the sequencer waits on it.
   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> (state_ff == S_SCAN))
      else $error("scan finished outside the scan step");

endmodule

### verif/ordered_sequence_store_top_test.sv
`timescale 1ns / 100ps

module ordered_sequence_store_top_test;
   import oss_pkg::*;

   // Store depth under test; the default keeps the bench in step with the package.
   localparam int STORE_DEPTH = DEFAULT_CAPACITY;
   localparam int TOTAL_ITEMS = 900;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT = 20000;

   // Command codes the block does not know; it must answer them with ok low.
   localparam logic [CMD_W-1:0] CODE_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CODE_SPARE_7 = 3'd7;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [INDEX_W-1:0]       index;
      logic [COUNT_W-1:0]       count;
      logic                     ok;
   } answer_type;

   typedef struct {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] data;
      logic signed [DATA_W-1:0] key;
      logic [POS_W-1:0]         pos;
      bit                       typed;
      answer_type               ans;
   } directed_row_type;

   // Every input holds a known value from time zero.
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command = '0;
   logic signed [DATA_W-1:0] req_data_value = '0;
   logic signed [DATA_W-1:0] req_search_key = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [INDEX_W-1:0]       rsp_result_index;
   logic [COUNT_W-1:0]       rsp_element_count;
   logic                     rsp_ok;

   // Shadow copy of the sequence, updated at every accepted request beat.
   logic signed [DATA_W-1:0] shadow_values [STORE_DEPTH];
   int                       shadow_count = 0;

   // Answers still owed by the block, oldest first.
   answer_type               pending_answers [$];
   directed_row_type         directed_rows [$];
   answer_type               front_answer;

   int items_sent = 0;
   int answers_seen = 0;
   int failure_count = 0;
   int burst_left = 0;
   bit long_hold_done = 1'b0;

   always #5 clock = ~clock;

   ordered_sequence_store_top #(
      .CAPACITY(STORE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_data_value   (req_data_value),
      .req_search_key   (req_search_key),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_result_index (rsp_result_index),
      .rsp_element_count(rsp_element_count),
      .rsp_ok           (rsp_ok)
   );

   // Work out the answer to one command and advance the shadow sequence.
   function automatic answer_type compute_answer(input logic [CMD_W-1:0] cmd,
                                                 input logic signed [DATA_W-1:0] data,
                                                 input logic signed [DATA_W-1:0] key,
                                                 input logic [POS_W-1:0] pos_bits);
      answer_type a;
      int         i;
      int         pos;
      a = '0;
      pos = pos_bits;
      case (cmd)
         CMD_APPEND: begin
            // Drop the value when the store is full; the count stays put.
            if (shadow_count < STORE_DEPTH) begin
               shadow_values[shadow_count] = data;
               shadow_count++;
               a.ok = 1'b1;
            end
         end
         CMD_FIND: begin
            // Stop at the lowest matching position.
            for (i = 0; i < shadow_count && !a.ok; i++) begin
               if (shadow_values[i] == key) begin
                  a.index = i[INDEX_W-1:0];
                  a.ok = 1'b1;
               end
            end
         end
         CMD_READ_AT: begin
            if (pos < shadow_count) begin
               a.value = shadow_values[pos];
               a.ok = 1'b1;
            end
         end
         CMD_REMOVE_AT: begin
            // Close the gap by moving every later entry down one place.
            if (pos < shadow_count) begin
               a.value = shadow_values[pos];
               a.ok = 1'b1;
               for (i = pos; i + 1 < shadow_count; i++) begin
                  shadow_values[i] = shadow_values[i + 1];
               end
               shadow_count--;
            end
         end
         CMD_READ_NEXT: begin
            if (pos + 1 < shadow_count) begin
               a.value = shadow_values[pos + 1];
               a.ok = 1'b1;
            end
         end
         CMD_COUNT: a.ok = 1'b1;
         default: a.ok = 1'b0;
      endcase
      a.count = shadow_count[COUNT_W-1:0];
      return a;
   endfunction

   // One value in four comes from a small pool so that finds hit and duplicates occur.
   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 3) != 0) return $urandom;
      case ($urandom_range(0, 5))
         0: return 32'sh0000_0000;
         1: return 32'sh0000_0001;
         2: return 32'shFFFF_FFFF;
         3: return 32'sh7FFF_FFFF;
         4: return 32'sh8000_0000;
         default: return $urandom_range(2, 5);
      endcase
   endfunction

   // Keys are taken from the live entries half the time, otherwise anything.
   function automatic logic signed [DATA_W-1:0] pick_key();
      if (shadow_count > 0 && $urandom_range(0, 1) == 0)
         return shadow_values[$urandom_range(0, shadow_count - 1)];
      return pick_value();
   endfunction

   // Positions mostly fall inside the sequence, the rest over the full field.
   function automatic logic [POS_W-1:0] pick_position();
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
         return $urandom_range(0, shadow_count - 1);
      return $urandom_range(0, (1 << POS_W) - 1);
   endfunction

   function automatic logic [CMD_W-1:0] pick_command();
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 14: return CMD_APPEND;
         4, 5:           return CMD_FIND;
         6, 7:           return CMD_READ_AT;
         8, 9, 15:       return CMD_REMOVE_AT;
         10, 11:         return CMD_READ_NEXT;
         12:             return CMD_COUNT;
         default:        return ($urandom_range(0, 1) != 0) ? CODE_SPARE_6 : CODE_SPARE_7;
      endcase
   endfunction

   task automatic report_failure(input string what);
      if (failure_count < 10) $display("[%0t] %s", $time, what);
      failure_count++;
   endtask

   task automatic add_row(input logic [CMD_W-1:0] cmd,
                          input logic signed [DATA_W-1:0] data,
                          input logic signed [DATA_W-1:0] key,
                          input logic [POS_W-1:0] pos,
                          input bit typed,
                          input logic signed [DATA_W-1:0] value,
                          input logic [INDEX_W-1:0] index,
                          input logic [COUNT_W-1:0] count,
                          input logic ok);
      directed_row_type row;
      row.cmd = cmd;
      row.data = data;
      row.key = key;
      row.pos = pos;
      row.typed = typed;
      row.ans = '{value, index, count, ok};
      directed_rows.push_back(row);
   endtask

   // Offer one request beat, hold it until taken, then book the answer owed.
   // Called right after a rising edge; leaves the sender in burst or gap.
   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic signed [DATA_W-1:0] data,
                            input logic signed [DATA_W-1:0] key,
                            input logic [POS_W-1:0] pos,
                            input bit typed = 1'b0,
                            input answer_type typed_ans = '0);
      answer_type predicted;
      int         gap;
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_data_value <= data;
      req_search_key <= key;
      req_position   <= pos;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = compute_answer(cmd, data, key, pos);
      pending_answers.push_back(typed ? typed_ans : predicted);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // End of burst: idle for a random gap, sometimes none at all.
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic send_random_item();
      send_item(pick_command(), pick_value(), pick_key(), pick_position());
   endtask

   // Stimulus: directed table first, then random phases of fill, drain and mix.
   initial begin : stimulus
      int phase;
      int drain_cycles;
      int n;

      // Right after reset: count zero, every read and remove out of range.
      add_row(CMD_COUNT,     0, 0, 0,  1, 0, 0, 0, 1);
      add_row(CMD_READ_AT,   0, 0, 0,  1, 0, 0, 0, 0);
      add_row(CMD_REMOVE_AT, 0, 0, 63, 1, 0, 0, 0, 0);
      add_row(CMD_READ_NEXT, 0, 0, 0,  1, 0, 0, 0, 0);
      add_row(CMD_FIND,      0, 0, 0,  1, 0, 0, 0, 0);
      // Extremes of the value field.
      add_row(CMD_APPEND, 32'sh7FFF_FFFF, 0, 0, 1, 0, 0, 1, 1);
      add_row(CMD_APPEND, 32'sh8000_0000, 0, 0, 1, 0, 0, 2, 1);
      add_row(CMD_APPEND, 32'sh0000_0000, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_APPEND, 32'shFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_READ_AT,   0, 0, 0,  1, 32'sh7FFF_FFFF, 0, 4, 1);
      add_row(CMD_READ_NEXT, 0, 0, 0,  1, 32'sh8000_0000, 0, 4, 1);
      // Next of the last entry and a position far past the end.
      add_row(CMD_READ_NEXT, 0, 0, 3,  1, 0, 0, 4, 0);
      add_row(CMD_READ_AT,   0, 0, 63, 1, 0, 0, 4, 0);
      add_row(CMD_FIND, 0, 32'shFFFF_FFFF, 0, 0, 0, 0, 0, 0);
      add_row(CMD_FIND, 0, 32'sh8000_0000, 0, 0, 0, 0, 0, 0);
      add_row(CMD_FIND, 0, 32'sh0000_3039, 0, 0, 0, 0, 0, 0);
      // Duplicate key: find must report the lowest position.
      add_row(CMD_APPEND, 32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_FIND, 0, 32'sh8000_0000, 0, 0, 0, 0, 0, 0);
      add_row(CMD_REMOVE_AT, 0, 0, 1, 0, 0, 0, 0, 0);
      add_row(CMD_READ_AT,   0, 0, 1, 0, 0, 0, 0, 0);
      // Unknown codes change nothing and report the count.
      add_row(CODE_SPARE_6, 0, 0, 0, 1, 0, 0, 4, 0);
      add_row(CODE_SPARE_7, 0, 0, 0, 1, 0, 0, 4, 0);
      // Remove the tail, then the head.
      add_row(CMD_REMOVE_AT, 0, 0, 3, 0, 0, 0, 0, 0);
      add_row(CMD_REMOVE_AT, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(CMD_COUNT,     0, 0, 0, 0, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].key,
                   directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].ans);
      end

      while (items_sent < TOTAL_ITEMS) begin
         phase = $urandom_range(0, 9);
         if (phase < 2) begin
            // Fill to capacity with some other traffic mixed in, then
            // push a few appends against the full store.
            while (shadow_count < STORE_DEPTH) begin
               if ($urandom_range(0, 4) == 0) send_random_item();
               else send_item(CMD_APPEND, pick_value(), pick_key(), pick_position());
            end
            n = $urandom_range(1, 3);
            repeat (n) send_item(CMD_APPEND, pick_value(), pick_key(), pick_position());
         end else if (phase < 4) begin
            // Drain by removal at random places, then poke the empty store.
            while (shadow_count > 0) begin
               send_item(CMD_REMOVE_AT, pick_value(), pick_key(), pick_position());
            end
            n = $urandom_range(1, 3);
            repeat (n) send_random_item();
         end else begin
            n = $urandom_range(10, 40);
            repeat (n) send_random_item();
         end
      end
      req_valid <= 1'b0;

      // Wait out every answer still owed, then a few more cycles for strays.
      drain_cycles = 0;
      while (pending_answers.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      if (pending_answers.size() != 0)
         report_failure($sformatf("%0d answers never arrived", pending_answers.size()));

      if (failure_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Result side: stretches of steady, random and periodic stalls, plus one
   // long hold-off that backs the block up and stalls its request side.
   initial begin : receiver
      int stall_mode;
      int stretch;
      int n;
      int hold_cycles;
      do @(posedge clock); while (reset);
      forever begin
         stall_mode = $urandom_range(0, 3);
         stretch = $urandom_range(20, 120);
         for (n = 0; n < stretch; n++) begin
            if (!long_hold_done && answers_seen >= 150) begin
               rsp_ready <= 1'b0;
               hold_cycles = 0;
               while (hold_cycles < LONG_HOLD_CYCLES) begin
                  @(posedge clock);
                  hold_cycles++;
               end
               long_hold_done = 1'b1;
            end else begin
               case (stall_mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_ready <= ((n % 4) != 3);
                  default: rsp_ready <= ($urandom_range(0, 1) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Check every result beat against the oldest answer owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            report_failure($sformatf("unexpected result beat: value %0d index %0d count %0d ok %0b",
                                     rsp_result_value, rsp_result_index,
                                     rsp_element_count, rsp_ok));
         end else begin
            front_answer = pending_answers.pop_front();
            if (rsp_result_value !== front_answer.value ||
                rsp_result_index !== front_answer.index ||
                rsp_element_count !== front_answer.count ||
                rsp_ok !== front_answer.ok) begin
               report_failure($sformatf({"result beat %0d mismatch: expected value %0d index %0d",
                                         " count %0d ok %0b, got value %0d index %0d count %0d",
                                         " ok %0b"},
                                        answers_seen, front_answer.value, front_answer.index,
                                        front_answer.count, front_answer.ok, rsp_result_value,
                                        rsp_result_index, rsp_element_count, rsp_ok));
            end
         end
      end
   end

   // Stop a hung run well past the slowest correct one.
   initial begin : watchdog
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### ordered_sequence_store_top.f
hdl/oss_pkg.sv
hdl/oss_cell.sv
hdl/oss_scan.sv
hdl/ordered_sequence_store_top.sv
verif/ordered_sequence_store_top_test.sv
